/* design/lr4_crossover_svf_macros.svh */
// Assertion helpers for the crossover block.
`ifndef LR4_CROSSOVER_SVF_MACROS_SVH
`define LR4_CROSSOVER_SVF_MACROS_SVH
`ifndef SYNTHESIS
`define LR4X_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LR4X_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LR4X_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define LR4X_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* design/lr4x_pkg.sv */
`timescale 1ns / 1ps
package lr4x_pkg;

   localparam int NUM_CHANNELS_DEF = 8;
   localparam int SAMPLE_BITS_DEF  = 24;

   // One state word holds the four integrators of a channel.
   localparam int INTEG_W = 32;
   localparam int WORD_W  = 4 * INTEG_W;

   localparam logic [23:0] WARP_GAIN_RST = 24'd68720;
   localparam logic [23:0] NORM_GAIN_RST = 24'd7646958;
   localparam logic [23:0] DAMPING_RST   = 24'd5931642;

   localparam logic [1:0] CSR_WARP_GAIN = 2'd0;
   localparam logic [1:0] CSR_NORM_GAIN = 2'd1;
   localparam logic [1:0] CSR_DAMPING   = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD,
      ST_M1,
      ST_A1,
      ST_M2,
      ST_A2,
      ST_M3,
      ST_A3,
      ST_M4,
      ST_A4,
      ST_M5,
      ST_A5,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ram_ctl_type;

endpackage

/* design/lr4x_state_ram.sv */
`timescale 1ns / 1ps
module lr4x_state_ram #(
   parameter int DEPTH = lr4x_pkg::NUM_CHANNELS_DEF,
   parameter int AW    = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lr4x_pkg::ram_ctl_type       ctl,
   input  logic [AW-1:0]               rd_addr,
   input  logic [AW-1:0]               wr_addr,
   input  logic [lr4x_pkg::WORD_W-1:0] wr_data,
   output logic [lr4x_pkg::WORD_W-1:0] rd_data
);

   logic [lr4x_pkg::WORD_W-1:0] mem_ff [DEPTH];
   logic [lr4x_pkg::WORD_W-1:0] rd_data_ff;
   logic [DEPTH-1:0]            vld_ff;
   logic                        rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // An entry never written since reset reads as all-zero integrators.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

/* design/lr4_crossover_svf.sv */
`timescale 1ns / 1ps
// A request beat is accepted only in ST_IDLE and worked through to the result
// one item at a time on the single shared multiplier (nine dependent multiplies,
// each a multiply state and an accumulate state) before ST_IDLE is reached again.
// Reset clears the channel valid bits so every integrator reads as zero,
// and loads the coefficient registers with their default values.
`include "lr4_crossover_svf_macros.svh"
module lr4_crossover_svf #(
   parameter int NUM_CHANNELS = lr4x_pkg::NUM_CHANNELS_DEF,
   parameter int SAMPLE_BITS  = lr4x_pkg::SAMPLE_BITS_DEF,
   localparam int REQ_W = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // sample_in
   input  logic [2:0]       req_tuser,   // chan_index
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // low_band, high_band
   output logic [2:0]       rsp_tuser,   // chan_out
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [23:0]      csr_data
);

   localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic signed [43:0] OUT_MAX = (44'sd1 <<< (SAMPLE_BITS - 1)) - 44'sd1;
   localparam logic signed [43:0] OUT_MIN = -OUT_MAX - 44'sd1;
   localparam logic signed [43:0] S32_MAX = 44'sd2147483647;
   localparam logic signed [43:0] S32_MIN = -44'sd2147483648;

   function automatic logic [2:0] chan_wrap(input logic [2:0] c);
      logic [6:0] v;
      v = {4'd0, c};
      for (int i = 0; i < 8; i++) begin
         if (v >= 7'(NUM_CHANNELS)) begin
            v = v - 7'(NUM_CHANNELS);
         end
      end
      return v[2:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
      if (v > S32_MAX) begin
         return 32'sh7fffffff;
      end else if (v < S32_MIN) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] sat_out(input logic signed [43:0] v);
      logic signed [43:0] r;
      r = v;
      if (v > OUT_MAX) begin
         r = OUT_MAX;
      end else if (v < OUT_MIN) begin
         r = OUT_MIN;
      end
      return r[SAMPLE_BITS-1:0];
   endfunction

   // Round to nearest with ties upwards, then floor shift.
   function automatic logic signed [40:0] rnd(input logic signed [59:0] p, input int sh);
      logic signed [59:0] q;
      q = (p + (60'sd1 <<< (sh - 1))) >>> sh;
      return q[40:0];
   endfunction

   lr4x_pkg::state_type   state_ff, state_in;
   lr4x_pkg::ram_ctl_type ram_ctl;

   logic [23:0] warp_gain_ff, norm_gain_ff, damping_ff;
   logic [26:0] rg_ff;

   logic signed [31:0] x_ff, ba_ff, la_ff, bb_ff, lb_ff;
   logic signed [31:0] op_ff, hp_ff, lp_ff, yh_a_ff, yb_a_ff, yl_a_ff;
   logic signed [59:0] prod_ff;
   logic               sec_ff;
   logic [2:0]         chan_ff;
   logic [AW-1:0]      addr_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             rsp_chan_ff;
   logic [SAMPLE_BITS-1:0] rsp_low_ff, rsp_high_ff;
   logic [SAMPLE_BITS-1:0] low_res_ff, high_res_ff;
   logic                   rsp_load;

   logic [lr4x_pkg::WORD_W-1:0] rd_data;
   logic [lr4x_pkg::WORD_W-1:0] wr_data;
   logic [AW-1:0]               rd_addr;

   logic [26:0]        mul_coef;
   logic signed [40:0] r20, r22, r23;
   logic signed [31:0] cur_band, cur_low, x_sec;
   logic signed [31:0] hp_pre, hp_n, bp_n, band_n, lp_n, low_n;
   logic signed [43:0] high_sum;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         warp_gain_ff <= lr4x_pkg::WARP_GAIN_RST;
         norm_gain_ff <= lr4x_pkg::NORM_GAIN_RST;
         damping_ff   <= lr4x_pkg::DAMPING_RST;
      end else if (csr_valid) begin
         case (csr_index)
            lr4x_pkg::CSR_WARP_GAIN: warp_gain_ff <= csr_data;
            lr4x_pkg::CSR_NORM_GAIN: norm_gain_ff <= csr_data;
            lr4x_pkg::CSR_DAMPING:   damping_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // damping + g in Q5.22, formed exactly.
   always_ff @(posedge clock) begin
      rg_ff <= {3'd0, damping_ff} + {1'b0, warp_gain_ff, 2'd0};
   end

   // State machine.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lr4x_pkg::ST_IDLE: if (req_tvalid) state_in = lr4x_pkg::ST_RD;
         lr4x_pkg::ST_RD:   state_in = lr4x_pkg::ST_M1;
         lr4x_pkg::ST_M1:   state_in = lr4x_pkg::ST_A1;
         lr4x_pkg::ST_A1:   state_in = lr4x_pkg::ST_M2;
         lr4x_pkg::ST_M2:   state_in = lr4x_pkg::ST_A2;
         lr4x_pkg::ST_A2:   state_in = lr4x_pkg::ST_M3;
         lr4x_pkg::ST_M3:   state_in = lr4x_pkg::ST_A3;
         lr4x_pkg::ST_A3:   state_in = lr4x_pkg::ST_M4;
         lr4x_pkg::ST_M4:   state_in = lr4x_pkg::ST_A4;
         lr4x_pkg::ST_A4:   state_in = sec_ff ? lr4x_pkg::ST_M5 : lr4x_pkg::ST_M1;
         lr4x_pkg::ST_M5:   state_in = lr4x_pkg::ST_A5;
         lr4x_pkg::ST_A5:   state_in = lr4x_pkg::ST_OUT;
         lr4x_pkg::ST_OUT:  if (rsp_load) state_in = lr4x_pkg::ST_IDLE;
         default:           state_in = lr4x_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = (state_ff == lr4x_pkg::ST_IDLE);
      ram_ctl.rd_en = (state_ff == lr4x_pkg::ST_IDLE) && req_tvalid;
      ram_ctl.wr_en = (state_ff == lr4x_pkg::ST_A5);
      rsp_load      = (state_ff == lr4x_pkg::ST_OUT) && (!rsp_valid_ff || rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lr4x_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // State store.
   assign rd_addr = AW'(chan_wrap(req_tuser));
   assign wr_data = {lb_ff, bb_ff, la_ff, ba_ff};

   lr4x_state_ram #(
      .DEPTH (NUM_CHANNELS),
      .AW    (AW)
   ) u_state_ram (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ram_ctl),
      .rd_addr (rd_addr),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // Shared multiplier operand selection.
   always_comb begin
      case (state_ff)
         lr4x_pkg::ST_M1: mul_coef = rg_ff;
         lr4x_pkg::ST_M2: mul_coef = 27'(norm_gain_ff);
         lr4x_pkg::ST_M3: mul_coef = 27'(warp_gain_ff);
         lr4x_pkg::ST_M4: mul_coef = 27'(warp_gain_ff);
         lr4x_pkg::ST_M5: mul_coef = 27'(damping_ff);
         default:         mul_coef = '0;
      endcase
   end

   // Accumulate-step arithmetic; sec_ff picks the second section's integrators.
   always_comb begin
      r20      = rnd(prod_ff, 20);
      r22      = rnd(prod_ff, 22);
      r23      = rnd(prod_ff, 23);
      cur_band = sec_ff ? bb_ff : ba_ff;
      cur_low  = sec_ff ? lb_ff : la_ff;
      x_sec    = sec_ff ? yl_a_ff : x_ff;
      hp_pre   = sat32(44'(x_sec) - 44'(r22) - 44'(cur_low));
      hp_n     = sat32(44'(r23));
      bp_n     = sat32(44'(r20) + 44'(cur_band));
      band_n   = sat32(44'(r20) + 44'(bp_n));
      lp_n     = sat32(44'(r20) + 44'(cur_low));
      low_n    = sat32(44'(r20) + 44'(lp_n));
      high_sum = 44'(yl_a_ff) - 44'(r22) + 44'(yh_a_ff) - 44'(lp_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff <= 1'b0;
      end else begin
         case (state_ff)
            lr4x_pkg::ST_RD: sec_ff <= 1'b0;
            lr4x_pkg::ST_A4: sec_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         lr4x_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               chan_ff <= req_tuser;
               addr_ff <= rd_addr;
               x_ff    <= 32'($signed(req_tdata[SAMPLE_BITS-1:0]));
            end
         end
         lr4x_pkg::ST_RD: begin
            ba_ff <= rd_data[31:0];
            la_ff <= rd_data[63:32];
            bb_ff <= rd_data[95:64];
            lb_ff <= rd_data[127:96];
            op_ff <= rd_data[31:0];
         end
         lr4x_pkg::ST_M1, lr4x_pkg::ST_M2, lr4x_pkg::ST_M3, lr4x_pkg::ST_M4,
         lr4x_pkg::ST_M5: begin
            prod_ff <= 60'(op_ff) * 60'($signed({1'b0, mul_coef}));
         end
         lr4x_pkg::ST_A1: op_ff <= hp_pre;
         lr4x_pkg::ST_A2: begin
            op_ff <= hp_n;
            hp_ff <= hp_n;
         end
         lr4x_pkg::ST_A3: begin
            op_ff <= bp_n;
            if (sec_ff) begin
               bb_ff <= band_n;
            end else begin
               ba_ff <= band_n;
            end
         end
         lr4x_pkg::ST_A4: begin
            lp_ff <= lp_n;
            if (sec_ff) begin
               lb_ff <= low_n;
               op_ff <= yb_a_ff;
            end else begin
               la_ff   <= low_n;
               yh_a_ff <= hp_ff;
               yb_a_ff <= op_ff;
               yl_a_ff <= lp_n;
               op_ff   <= bb_ff;
            end
         end
         lr4x_pkg::ST_A5: begin
            low_res_ff  <= sat_out(44'(lp_ff));
            high_res_ff <= sat_out(high_sum);
         end
         default: ;
      endcase
   end

   // Output register: the next request is taken while a result waits here.
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_chan_ff <= chan_ff;
         rsp_low_ff  <= low_res_ff;
         rsp_high_ff <= high_res_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_chan_ff;
   assign rsp_tdata  = RSP_W'({rsp_high_ff, rsp_low_ff});

   `LR4X_ASSERT_NEXT(a_accept_reads, clock, reset, req_tvalid && req_tready, state_ff == lr4x_pkg::ST_RD, "accepted beat did not start a state read")
   `LR4X_ASSERT_NEXT(a_first_section, clock, reset, state_ff == lr4x_pkg::ST_RD, !sec_ff && state_ff == lr4x_pkg::ST_M1, "item started in the second section")
   `LR4X_ASSERT_IMPLY(a_final_section, clock, reset, state_ff == lr4x_pkg::ST_M5 || state_ff == lr4x_pkg::ST_A5, sec_ff, "band output formed before the second section")
   `LR4X_ASSERT_NEXT(a_result_shown, clock, reset, rsp_load, rsp_tvalid && state_ff == lr4x_pkg::ST_IDLE, "loaded result not presented")

endmodule
